/* rtl/s_record_stream_parser_remap_defines.svh */
// ============================================================================
// S-record parser assertion macros
// Shared concurrent assertion forms used by the parser RTL.
// ============================================================================
`ifndef S_RECORD_STREAM_PARSER_REMAP_DEFINES_SVH
`define S_RECORD_STREAM_PARSER_REMAP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled in reset.
`define SRSPR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled in reset.
`define SRSPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/srspr_pkg.sv */
// ============================================================================
// S-record parser package
// Types, constants and small decode functions shared by the parser files.
// ============================================================================
package srspr_pkg;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_WAIT  = 3'd0,
    PH_TYPE  = 3'd1,
    PH_COUNT = 3'd2,
    PH_ADDR  = 3'd3,
    PH_DATA  = 3'd4,
    PH_CSUM  = 3'd5,
    PH_TAIL  = 3'd6,
    PH_SKIP  = 3'd7
  } phase_e;

  // Configuration register indexes (word offsets on the APB port).
  typedef enum logic [2:0] {
    REG_MAP_LOW     = 3'd0,
    REG_MAP_HIGH    = 3'd1,
    REG_MAP_TARGET  = 3'd2,
    REG_BASE_OFFSET = 3'd3,
    REG_DEL_ENABLE  = 3'd4,
    REG_DEL_LOW     = 3'd5,
    REG_DEL_HIGH    = 3'd6,
    REG_CUT_ENABLE  = 3'd7
  } cfg_reg_e;

  localparam int unsigned PaddrW = 5;

  localparam logic [7:0]  CHAR_S     = 8'h53;
  localparam logic [7:0]  CHAR_NL    = 8'h0A;
  localparam logic [7:0]  CHAR_0     = 8'h30;
  localparam logic [7:0]  CHAR_9     = 8'h39;
  localparam logic [7:0]  CHAR_UA    = 8'h41;
  localparam logic [7:0]  CHAR_UF    = 8'h46;
  localparam logic [7:0]  CHAR_LA    = 8'h61;
  localparam logic [7:0]  CHAR_LF    = 8'h66;
  localparam logic [3:0]  TYPE_BAD   = 4'hF;
  localparam logic [31:0] ADDR24_MAX = 32'h00ff_ffff;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Record types with a special meaning.
  localparam logic [3:0] TYPE_S0 = 4'd0;
  localparam logic [3:0] TYPE_S1 = 4'd1;
  localparam logic [3:0] TYPE_S2 = 4'd2;
  localparam logic [3:0] TYPE_S3 = 4'd3;
  localparam logic [3:0] TYPE_S4 = 4'd4;
  localparam logic [3:0] TYPE_S6 = 4'd6;
  localparam logic [3:0] TYPE_S7 = 4'd7;
  localparam logic [3:0] TYPE_S8 = 4'd8;

  // Configuration as seen by the parser, with the remap offsets folded.
  typedef struct packed {
    logic [31:0] map_low;
    logic [31:0] map_high;
    logic [31:0] off_in;   // map_target - map_low - base_offset
    logic [31:0] off_out;  // -base_offset
    logic        delete_enable;
    logic [31:0] delete_low;
    logic [31:0] delete_high;
    logic        cut_enable;
  } cfg_t;

  // One result word.
  typedef struct packed {
    logic        result_kind;
    logic [31:0] address;
    logic [7:0]  data_byte;
    logic [3:0]  in_type;
    logic [3:0]  out_type;
    logic        checksum_ok;
    logic        dropped;
    logic        format_error;
    logic [15:0] record_count;
  } res_t;

  // Number of address bytes for a record type.
  function automatic logic [2:0] addr_len(input logic [3:0] t);
    logic [2:0] n;
    if (t == TYPE_S2 || t == TYPE_S8) begin
      n = 3'd3;
    end else if (t == TYPE_S3 || t == TYPE_S7) begin
      n = 3'd4;
    end else begin
      n = 3'd2;
    end
    return n;
  endfunction

  // S1, S2 and S3 carry data.
  function automatic logic is_data_type(input logic [3:0] t);
    return (t == TYPE_S1) || (t == TYPE_S2) || (t == TYPE_S3);
  endfunction

endpackage

/* rtl/srspr_char_if.sv */
// ============================================================================
// S-record character channel
// Valid/ready channel that moves one text character per word.
// ============================================================================
interface srspr_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;

  modport source (output valid, output text_char, input ready);
  modport sink   (input valid, input text_char, output ready);
endinterface

/* rtl/srspr_result_if.sv */
// ============================================================================
// S-record result channel
// Valid/ready channel that moves one parser result per word.
// ============================================================================
interface srspr_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] address;
  logic [7:0]  data_byte;
  logic [3:0]  in_type;
  logic [3:0]  out_type;
  logic        checksum_ok;
  logic        dropped;
  logic        format_error;
  logic [15:0] record_count;

  modport source (
    output valid, output result_kind, output address, output data_byte,
    output in_type, output out_type, output checksum_ok, output dropped,
    output format_error, output record_count, input ready
  );
  modport sink (
    input valid, input result_kind, input address, input data_byte,
    input in_type, input out_type, input checksum_ok, input dropped,
    input format_error, input record_count, output ready
  );
endinterface

/* rtl/srspr_cfg.sv */
// ============================================================================
// S-record parser configuration registers
// APB register file; also folds the remap and base offsets into two sums.
// ============================================================================
module srspr_cfg
  import srspr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [31:0] map_low_q, map_high_q, map_target_q, base_offset_q;
  logic [31:0] delete_low_q, delete_high_q;
  logic        delete_enable_q, cut_enable_q;
  logic [31:0] tgt_low_q, off_in_q, off_out_q;
  logic        wr_en;
  cfg_reg_e    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = cfg_reg_e'(paddr[PaddrW-1:2]);

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_low_q       <= '0;
      map_high_q      <= '0;
      map_target_q    <= '0;
      base_offset_q   <= '0;
      delete_enable_q <= 1'b0;
      delete_low_q    <= '0;
      delete_high_q   <= '0;
      cut_enable_q    <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MAP_LOW:     map_low_q       <= pwdata;
        REG_MAP_HIGH:    map_high_q      <= pwdata;
        REG_MAP_TARGET:  map_target_q    <= pwdata;
        REG_BASE_OFFSET: base_offset_q   <= pwdata;
        REG_DEL_ENABLE:  delete_enable_q <= pwdata[0];
        REG_DEL_LOW:     delete_low_q    <= pwdata;
        REG_DEL_HIGH:    delete_high_q   <= pwdata;
        REG_CUT_ENABLE:  cut_enable_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Folded offsets, one subtraction per register. Records only use them
  // several characters after any write, so the register lag is hidden.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_low_q <= '0;
      off_in_q  <= '0;
      off_out_q <= '0;
    end else begin
      tgt_low_q <= map_target_q - map_low_q;
      off_in_q  <= tgt_low_q - base_offset_q;
      off_out_q <= 32'd0 - base_offset_q;
    end
  end

  // Read mux.
  always_comb begin
    case (reg_idx)
      REG_MAP_LOW:     prdata = map_low_q;
      REG_MAP_HIGH:    prdata = map_high_q;
      REG_MAP_TARGET:  prdata = map_target_q;
      REG_BASE_OFFSET: prdata = base_offset_q;
      REG_DEL_ENABLE:  prdata = {31'd0, delete_enable_q};
      REG_DEL_LOW:     prdata = delete_low_q;
      REG_DEL_HIGH:    prdata = delete_high_q;
      REG_CUT_ENABLE:  prdata = {31'd0, cut_enable_q};
      default:         prdata = '0;
    endcase
  end

  assign cfg_o.map_low       = map_low_q;
  assign cfg_o.map_high      = map_high_q;
  assign cfg_o.off_in        = off_in_q;
  assign cfg_o.off_out       = off_out_q;
  assign cfg_o.delete_enable = delete_enable_q;
  assign cfg_o.delete_low    = delete_low_q;
  assign cfg_o.delete_high   = delete_high_q;
  assign cfg_o.cut_enable    = cut_enable_q;

endmodule

/* rtl/s_record_stream_parser_remap.sv */
// ============================================================================
// S-record stream parser with address remap
// Parses S-record text one character per word and emits data bytes with
// their output addresses and one summary word at the end of each record.
// ============================================================================
// The block accepts one character every clock cycle while its output
// buffer has room. A character that completes a checksum, a data byte of
// a kept S1, S2 or S3 record, or that breaks the format yields one result
// word, registered into a two-word output buffer. Input keeps flowing
// while one result waits; the input stalls only when both words are full.
// The record output address is computed in one registered add in the cycle
// after the last address character, well before the first data byte completes.
`include "s_record_stream_parser_remap_defines.svh"

module s_record_stream_parser_remap
  import srspr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  srspr_char_if.sink        char_in,
  srspr_result_if.source    res_out,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t cfg;

  srspr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Parser state.
  phase_e      phase_q, phase_d;
  logic [3:0]  type_q, type_d;
  logic [7:0]  left_q, left_d;
  logic [31:0] acc_q, acc_d;
  logic [3:0]  hi_q, hi_d;
  logic        pend_q, pend_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  idx_q, idx_d;
  logic [15:0] records_q, records_d;

  // Record address stage.
  logic [31:0] rec_addr_q;
  logic        drop_q;

  // Output buffer.
  logic        out_v_q, skid_v_q;
  res_t        out_q, skid_q;

  logic        accept, push, pop;
  res_t        res;
  logic [7:0]  c;
  logic        is_digit, is_hex;
  logic [3:0]  nib;
  logic [7:0]  b;
  logic [2:0]  al;
  logic [3:0]  kind_t;
  logic        in_win, in_del;

  assign c      = char_in.text_char;
  assign accept = char_in.valid && char_in.ready;
  assign char_in.ready = !skid_v_q;

  // Character decode.
  always_comb begin
    is_digit = (c >= CHAR_0) && (c <= CHAR_9);
    is_hex   = 1'b1;
    if (is_digit) begin
      nib = 4'(c - CHAR_0);
    end else if ((c >= CHAR_UA) && (c <= CHAR_UF)) begin
      nib = 4'(c - CHAR_UA + 8'd10);
    end else if ((c >= CHAR_LA) && (c <= CHAR_LF)) begin
      nib = 4'(c - CHAR_LA + 8'd10);
    end else begin
      nib    = 4'd0;
      is_hex = 1'b0;
    end
  end

  assign b  = {hi_q, nib};
  assign al = addr_len(type_q);

  // Output type after cut and 24-bit promotion.
  always_comb begin
    kind_t = type_q;
    if (cfg.cut_enable && type_q == TYPE_S3) begin
      kind_t = TYPE_S2;
    end
    if (cfg.cut_enable && type_q == TYPE_S7) begin
      kind_t = TYPE_S8;
    end
    if ((kind_t == TYPE_S1 || kind_t == TYPE_S2) && (|rec_addr_q[31:24])) begin
      kind_t = TYPE_S3;
    end
  end

  // Record address and delete check, taken from the settled address.
  assign in_win = (acc_q >= cfg.map_low) && (acc_q <= cfg.map_high);
  assign in_del = (acc_q >= cfg.delete_low) && (acc_q <= cfg.delete_high);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_addr_q <= '0;
      drop_q     <= 1'b0;
    end else begin
      if (is_data_type(type_q)) begin
        rec_addr_q <= acc_q + (in_win ? cfg.off_in : cfg.off_out);
      end else begin
        rec_addr_q <= acc_q;
      end
      drop_q <= cfg.delete_enable && is_data_type(type_q) && in_del;
    end
  end

  // Next state and result for one character.
  always_comb begin
    phase_d   = phase_q;
    type_d    = type_q;
    left_d    = left_q;
    acc_d     = acc_q;
    hi_d      = hi_q;
    pend_d    = pend_q;
    sum_d     = sum_q;
    idx_d     = idx_q;
    records_d = records_q;
    push      = 1'b0;
    res       = '0;

    case (phase_q)
      PH_WAIT: begin
        if (c == CHAR_S) begin
          phase_d = PH_TYPE;
          type_d  = TYPE_S0;
          pend_d  = 1'b0;
        end
      end
      PH_TAIL, PH_SKIP: begin
        if (c == CHAR_NL) begin
          phase_d = PH_WAIT;
        end
      end
      PH_TYPE: begin
        pend_d = 1'b0;
        if (c == CHAR_NL) begin
          type_d  = TYPE_BAD;
          phase_d = PH_WAIT;
          push    = 1'b1;
        end else if (!is_digit) begin
          type_d  = TYPE_BAD;
          phase_d = PH_SKIP;
          push    = 1'b1;
        end else begin
          type_d = nib;
          if (nib == TYPE_S4 || nib == TYPE_S6) begin
            phase_d = PH_SKIP;
            push    = 1'b1;
          end else begin
            phase_d = PH_COUNT;
          end
        end
      end
      default: begin
        // Hex phases: count, address, data and checksum.
        if (c == CHAR_NL) begin
          phase_d = PH_WAIT;
          pend_d  = 1'b0;
          push    = 1'b1;
        end else if (!is_hex) begin
          phase_d = PH_SKIP;
          pend_d  = 1'b0;
          push    = 1'b1;
        end else if (!pend_q) begin
          hi_d   = nib;
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
          case (phase_q)
            PH_COUNT: begin
              sum_d = b;
              if (b < ({5'd0, al} + 8'd1)) begin
                phase_d = PH_SKIP;
                push    = 1'b1;
              end else begin
                left_d  = b;
                idx_d   = 8'd0;
                acc_d   = 32'd0;
                phase_d = PH_ADDR;
              end
            end
            PH_ADDR: begin
              sum_d  = sum_q + b;
              acc_d  = {acc_q[23:0], b};
              left_d = left_q - 8'd1;
              idx_d  = idx_q + 8'd1;
              if (idx_d == {5'd0, al}) begin
                idx_d   = 8'd0;
                phase_d = (left_d == 8'd1) ? PH_CSUM : PH_DATA;
              end
            end
            PH_DATA: begin
              sum_d  = sum_q + b;
              left_d = left_q - 8'd1;
              if (is_data_type(type_q) && !drop_q) begin
                push             = 1'b1;
                res.result_kind  = KIND_DATA;
                res.address      = rec_addr_q + {24'd0, idx_q};
                res.data_byte    = b;
                res.in_type      = type_q;
                res.out_type     = kind_t;
                res.record_count = records_q;
              end
              idx_d = idx_q + 8'd1;
              if (left_d == 8'd1) begin
                phase_d = PH_CSUM;
              end
            end
            PH_CSUM: begin
              if (is_data_type(type_q) && !drop_q) begin
                records_d = records_q + 16'd1;
              end
              push             = 1'b1;
              res.result_kind  = KIND_END;
              res.address      = rec_addr_q;
              res.in_type      = type_q;
              res.out_type     = kind_t;
              res.checksum_ok  = (type_q == TYPE_S0) || (~sum_q == b);
              res.dropped      = drop_q;
              res.record_count = records_d;
              phase_d          = PH_TAIL;
            end
            default: ;
          endcase
        end
      end
    endcase

    // Every result pushed from an error path is a format error word.
    if (push && (phase_d == PH_SKIP || phase_d == PH_WAIT)) begin
      res              = '0;
      res.result_kind  = KIND_END;
      res.in_type      = type_d;
      res.out_type     = type_d;
      res.format_error = 1'b1;
      res.record_count = records_q;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_WAIT;
      type_q    <= 4'd0;
      left_q    <= 8'd0;
      acc_q     <= 32'd0;
      hi_q      <= 4'd0;
      pend_q    <= 1'b0;
      sum_q     <= 8'd0;
      idx_q     <= 8'd0;
      records_q <= 16'd0;
    end else if (accept) begin
      phase_q   <= phase_d;
      type_q    <= type_d;
      left_q    <= left_d;
      acc_q     <= acc_d;
      hi_q      <= hi_d;
      pend_q    <= pend_d;
      sum_q     <= sum_d;
      idx_q     <= idx_d;
      records_q <= records_d;
    end
  end

  // Two-word output buffer: head word plus skid word.
  assign pop = out_v_q && res_out.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_v_q) begin
          skid_v_q <= 1'b0;
        end else begin
          out_v_q <= accept && push;
        end
      end else if (accept && push) begin
        if (!out_v_q) begin
          out_v_q <= 1'b1;
        end else begin
          skid_v_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (accept && push) begin
        out_q <= res;
      end
    end else if (accept && push) begin
      if (!out_v_q) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign res_out.valid        = out_v_q;
  assign res_out.result_kind  = out_q.result_kind;
  assign res_out.address      = out_q.address;
  assign res_out.data_byte    = out_q.data_byte;
  assign res_out.in_type      = out_q.in_type;
  assign res_out.out_type     = out_q.out_type;
  assign res_out.checksum_ok  = out_q.checksum_ok;
  assign res_out.dropped      = out_q.dropped;
  assign res_out.format_error = out_q.format_error;
  assign res_out.record_count = out_q.record_count;

  // The skid word is only ever filled behind a valid head word.
  `SRSPR_ASSERT_IMPL(a_skid_behind_head, skid_v_q, out_v_q,
                     "skid word valid while head word empty")

  // A half byte is held only inside the hex fields of a record.
  `SRSPR_ASSERT_IMPL(a_pend_in_hex, pend_q,
                     (phase_q == PH_COUNT) || (phase_q == PH_ADDR) ||
                     (phase_q == PH_DATA) || (phase_q == PH_CSUM),
                     "pending nibble outside hex phases")

  // Data words never carry error or checksum flags.
  `SRSPR_ASSERT_IMPL(a_data_word_clean, out_v_q && (out_q.result_kind == KIND_DATA),
                     !out_q.format_error && !out_q.checksum_ok && !out_q.dropped,
                     "data word with end-of-record flags")

  // Data bytes start at index zero once the address is complete.
  `SRSPR_ASSERT_NEXT(a_data_starts_at_zero,
                     accept && (phase_q == PH_ADDR) && (phase_d == PH_DATA),
                     idx_q == 8'd0, "byte index not cleared after address")

endmodule

/* tb/sv/srspr_decode_checker.sv */
// ----------------------------------------------------------------------------
// S-record parser result checker
// Watches the character channel, the result channel and the APB register
// writes. A local decoder follows the text character by character, queues
// the words that the parser must produce, and compares every result word,
// field by field, with the oldest word still due.
// ----------------------------------------------------------------------------
module srspr_decode_checker
  import srspr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  srspr_char_if             char_mon,
  srspr_result_if           res_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int unsigned       mismatch_count_o,
  output int unsigned       words_outstanding_o
);

  // Register copies, written from the APB port.
  logic [31:0] map_low_q, map_high_q, map_target_q, base_offset_q;
  logic [31:0] del_low_q, del_high_q;
  logic        del_enable_q, cut_enable_q;

  // Decoder state.
  phase_e      phase_q;
  logic [3:0]  rec_type_q;
  logic [7:0]  bytes_left_q;
  logic [7:0]  byte_idx_q;
  logic [7:0]  run_sum_q;
  logic [31:0] addr_acc_q;
  logic [3:0]  hi_nib_q;
  logic        nib_pend_q;
  logic        drop_rec_q;
  logic [15:0] rec_count_q;

  // Words the parser still owes, oldest first.
  res_t decoded_words[$];

  // Number of address bytes that a record type carries.
  function automatic int addr_bytes(input logic [3:0] t);
    if (t == TYPE_S2 || t == TYPE_S8) return 3;
    if (t == TYPE_S3 || t == TYPE_S7) return 4;
    return 2;
  endfunction

  function automatic logic carries_data(input logic [3:0] t);
    return (t == TYPE_S1) || (t == TYPE_S2) || (t == TYPE_S3);
  endfunction

  // Output address of the current record: remap window, then base offset.
  function automatic logic [31:0] rec_out_addr();
    logic [31:0] a;
    a = addr_acc_q;
    if (!carries_data(rec_type_q)) return a;
    if (a >= map_low_q && a <= map_high_q) a = a - map_low_q + map_target_q;
    return a - base_offset_q;
  endfunction

  // Output record type after cut and promotion past 24 bits.
  function automatic logic [3:0] rec_out_type();
    logic [3:0] t;
    t = rec_type_q;
    if (cut_enable_q && t == TYPE_S3) t = TYPE_S2;
    if (cut_enable_q && t == TYPE_S7) t = TYPE_S8;
    if ((t == TYPE_S1 || t == TYPE_S2) && rec_out_addr() > ADDR24_MAX) t = TYPE_S3;
    return t;
  endfunction

  // Error word; the rest of the line is skipped or a new record may start.
  task automatic format_fault(input phase_e next_ph, output res_t w);
    w              = '0;
    w.result_kind  = KIND_END;
    w.in_type      = rec_type_q;
    w.out_type     = rec_type_q;
    w.format_error = 1'b1;
    w.record_count = rec_count_q;
    phase_q        = next_ph;
    nib_pend_q     = 1'b0;
  endtask

  // One decoded byte of count, address, data or checksum.
  task automatic take_byte(input logic [7:0] b, output bit hit, output res_t w);
    int alen;
    alen = addr_bytes(rec_type_q);
    hit  = 1'b0;
    w    = '0;
    case (phase_q)
      PH_COUNT: begin
        run_sum_q = b;
        if (int'(b) < alen + 1) begin
          format_fault(PH_SKIP, w);
          hit = 1'b1;
        end else begin
          bytes_left_q = b;
          byte_idx_q   = '0;
          addr_acc_q   = '0;
          phase_q      = PH_ADDR;
        end
      end
      PH_ADDR: begin
        run_sum_q    = run_sum_q + b;
        addr_acc_q   = {addr_acc_q[23:0], b};
        bytes_left_q = bytes_left_q - 8'd1;
        byte_idx_q   = byte_idx_q + 8'd1;
        if (int'(byte_idx_q) == alen) begin
          drop_rec_q = del_enable_q && carries_data(rec_type_q) &&
                       addr_acc_q >= del_low_q && addr_acc_q <= del_high_q;
          byte_idx_q = '0;
          phase_q    = (bytes_left_q == 8'd1) ? PH_CSUM : PH_DATA;
        end
      end
      PH_DATA: begin
        run_sum_q    = run_sum_q + b;
        bytes_left_q = bytes_left_q - 8'd1;
        if (carries_data(rec_type_q) && !drop_rec_q) begin
          hit            = 1'b1;
          w.result_kind  = KIND_DATA;
          w.address      = rec_out_addr() + {24'd0, byte_idx_q};
          w.data_byte    = b;
          w.in_type      = rec_type_q;
          w.out_type     = rec_out_type();
          w.record_count = rec_count_q;
        end
        byte_idx_q = byte_idx_q + 8'd1;
        if (bytes_left_q == 8'd1) phase_q = PH_CSUM;
      end
      PH_CSUM: begin
        // A data record counts when not dropped, whatever its checksum.
        if (carries_data(rec_type_q) && !drop_rec_q) rec_count_q = rec_count_q + 16'd1;
        hit            = 1'b1;
        w.result_kind  = KIND_END;
        w.address      = rec_out_addr();
        w.in_type      = rec_type_q;
        w.out_type     = rec_out_type();
        w.checksum_ok  = (rec_type_q == TYPE_S0) || (8'(~run_sum_q) == b);
        w.dropped      = drop_rec_q;
        w.record_count = rec_count_q;
        phase_q        = PH_TAIL;
      end
      default: ;
    endcase
  endtask

  // Follows one text character and tells whether it yields a word.
  task automatic decode_char(input logic [7:0] c, output bit hit, output res_t w);
    logic [3:0] nib;
    bit         is_hex;
    hit    = 1'b0;
    w      = '0;
    nib    = '0;
    is_hex = 1'b0;
    case (phase_q)
      PH_WAIT: begin
        // Everything before an S is ignored.
        if (c == CHAR_S) begin
          phase_q    = PH_TYPE;
          rec_type_q = TYPE_S0;
          drop_rec_q = 1'b0;
          nib_pend_q = 1'b0;
        end
      end
      PH_TAIL, PH_SKIP: begin
        if (c == CHAR_NL) phase_q = PH_WAIT;
      end
      PH_TYPE: begin
        if (c == CHAR_NL) begin
          rec_type_q = TYPE_BAD;
          format_fault(PH_WAIT, w);
          hit = 1'b1;
        end else if (c < CHAR_0 || c > CHAR_9) begin
          rec_type_q = TYPE_BAD;
          format_fault(PH_SKIP, w);
          hit = 1'b1;
        end else begin
          rec_type_q = 4'(c - CHAR_0);
          if (rec_type_q == TYPE_S4 || rec_type_q == TYPE_S6) begin
            format_fault(PH_SKIP, w);
            hit = 1'b1;
          end else begin
            phase_q    = PH_COUNT;
            nib_pend_q = 1'b0;
          end
        end
      end
      default: begin
        if (c >= CHAR_0 && c <= CHAR_9) begin
          nib    = 4'(c - CHAR_0);
          is_hex = 1'b1;
        end else if (c >= CHAR_UA && c <= CHAR_UF) begin
          nib    = 4'(c - CHAR_UA + 8'd10);
          is_hex = 1'b1;
        end else if (c >= CHAR_LA && c <= CHAR_LF) begin
          nib    = 4'(c - CHAR_LA + 8'd10);
          is_hex = 1'b1;
        end
        if (c == CHAR_NL) begin
          format_fault(PH_WAIT, w);
          hit = 1'b1;
        end else if (!is_hex) begin
          format_fault(PH_SKIP, w);
          hit = 1'b1;
        end else if (!nib_pend_q) begin
          hi_nib_q   = nib;
          nib_pend_q = 1'b1;
        end else begin
          nib_pend_q = 1'b0;
          take_byte({hi_nib_q, nib}, hit, w);
        end
      end
    endcase
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      mismatch_count_o++;
    end
  endtask

  // Configuration tracking, prediction and comparison on each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin : track
    bit   hit;
    res_t w;
    res_t want;
    if (!rst_ni) begin
      map_low_q           = '0;
      map_high_q          = '0;
      map_target_q        = '0;
      base_offset_q       = '0;
      del_enable_q        = 1'b0;
      del_low_q           = '0;
      del_high_q          = '0;
      cut_enable_q        = 1'b0;
      phase_q             = PH_WAIT;
      rec_type_q          = '0;
      bytes_left_q        = '0;
      byte_idx_q          = '0;
      run_sum_q           = '0;
      addr_acc_q          = '0;
      hi_nib_q            = '0;
      nib_pend_q          = 1'b0;
      drop_rec_q          = 1'b0;
      rec_count_q         = '0;
      decoded_words.delete();
      mismatch_count_o    = 0;
      words_outstanding_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_e'(paddr[4:2]))
          REG_MAP_LOW:     map_low_q     = pwdata;
          REG_MAP_HIGH:    map_high_q    = pwdata;
          REG_MAP_TARGET:  map_target_q  = pwdata;
          REG_BASE_OFFSET: base_offset_q = pwdata;
          REG_DEL_ENABLE:  del_enable_q  = pwdata[0];
          REG_DEL_LOW:     del_low_q     = pwdata;
          REG_DEL_HIGH:    del_high_q    = pwdata;
          REG_CUT_ENABLE:  cut_enable_q  = pwdata[0];
          default: ;
        endcase
      end

      if (char_mon.valid && char_mon.ready) begin
        decode_char(char_mon.text_char, hit, w);
        if (hit) decoded_words.push_back(w);
      end

      if (res_mon.valid && res_mon.ready) begin
        if (decoded_words.size() == 0) begin
          $display("%0t: result word with none due, actual kind %0b address %0h",
                   $time, res_mon.result_kind, res_mon.address);
          mismatch_count_o++;
        end else begin
          want = decoded_words.pop_front();
          check_field("result_kind", want.result_kind, res_mon.result_kind);
          check_field("address", want.address, res_mon.address);
          check_field("data_byte", want.data_byte, res_mon.data_byte);
          check_field("in_type", want.in_type, res_mon.in_type);
          check_field("out_type", want.out_type, res_mon.out_type);
          check_field("checksum_ok", want.checksum_ok, res_mon.checksum_ok);
          check_field("dropped", want.dropped, res_mon.dropped);
          check_field("format_error", want.format_error, res_mon.format_error);
          check_field("record_count", want.record_count, res_mon.record_count);
        end
      end
      words_outstanding_o = decoded_words.size();
    end
  end

endmodule

/* tb/sv/tb_s_record_stream_parser_remap.sv */
// ----------------------------------------------------------------------------
// S-record parser testbench
// Feeds S-record text with random idles and result stalls through several
// register settings: a short directed set of records first, then random
// records that are mostly well formed with some broken ones and line noise.
// The checker beside the parser predicts and compares each result word.
// ----------------------------------------------------------------------------
module tb_s_record_stream_parser_remap;
  import srspr_pkg::*;

  localparam logic [3:0] TYPE_S5     = 4'd5;
  localparam logic [3:0] TYPE_S9     = 4'd9;
  localparam int         PHASE_CHARS = 110;
  localparam int         NUM_PHASES  = 5;
  localparam int         CYCLE_LIMIT = 400000;

  // Ways in which a generated record is broken.
  typedef enum int {
    REC_CLEAN,
    REC_BAD_SUM,
    REC_BAD_DIGIT,
    REC_EARLY_NL,
    REC_SHORT_COUNT
  } rec_flaw_e;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int unsigned fail_cnt;
  int unsigned words_left;
  int          cycle_cnt = 0;
  int          char_total;
  bit          calm;
  logic [31:0] cfg_shadow[8];
  logic [7:0]  line_q[$];

  srspr_char_if   char_ch();
  srspr_result_if res_ch();

  s_record_stream_parser_remap dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_in (char_ch),
    .res_out (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  srspr_decode_checker checker_u (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .char_mon            (char_ch),
    .res_mon             (res_ch),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .pready              (pready),
    .mismatch_count_o    (fail_cnt),
    .words_outstanding_o (words_left)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Result side stalls about a quarter of the time unless in a calm stretch.
  always @(negedge clk_i) begin
    res_ch.ready <= calm || ($urandom_range(0, 99) >= 25);
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // APB write: setup phase, access phase, then idle.
  task automatic reg_write(input cfg_reg_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    cfg_shadow[idx] = val;
    @(negedge clk_i);
  endtask

  // One character word, with random idles in front of it.
  task automatic send_char(input logic [7:0] c);
    while (!calm && $urandom_range(0, 99) < 25) begin
      char_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    char_ch.valid     <= 1'b1;
    char_ch.text_char <= c;
    @(posedge clk_i);
    while (!char_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_char(line_q[i]);
    char_total += line_q.size();
  endtask

  // Stop the text, wait for every word due and let the pipeline drain.
  task automatic settle();
    char_ch.valid <= 1'b0;
    while (words_left != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return CHAR_0 + 8'(n);
    return ($urandom_range(0, 1) ? CHAR_LA : CHAR_UA) + 8'(n - 4'd10);
  endfunction

  function automatic bit is_hex_char(input logic [7:0] c);
    return (c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_UA && c <= CHAR_UF) ||
           (c >= CHAR_LA && c <= CHAR_LF);
  endfunction

  // Any byte except the given one.
  function automatic logic [7:0] any_char_but(input logic [7:0] avoid);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == avoid);
    return c;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_hex_char(c) || c == CHAR_NL);
    return c;
  endfunction

  task automatic push_hex(input logic [7:0] b);
    line_q.push_back(hex_char(b[7:4]));
    line_q.push_back(hex_char(b[3:0]));
  endtask

  // Builds one record line, optionally broken, with noise around it.
  task automatic build_record(input logic [3:0] rtype, input logic [31:0] addr,
                              input int ndata, input rec_flaw_e flaw);
    int         alen;
    int         count;
    int         first_hex;
    int         hex_end;
    int         pos;
    logic [7:0] sum;
    logic [7:0] b;
    line_q.delete();
    repeat ($urandom_range(0, 2)) line_q.push_back(any_char_but(CHAR_S));
    line_q.push_back(CHAR_S);
    line_q.push_back(CHAR_0 + 8'(rtype));
    first_hex = line_q.size();
    if (rtype == TYPE_S2 || rtype == TYPE_S8) alen = 3;
    else if (rtype == TYPE_S3 || rtype == TYPE_S7) alen = 4;
    else alen = 2;
    count = alen + ndata + 1;
    if (flaw == REC_SHORT_COUNT) count = $urandom_range(0, alen);
    sum = 8'(count);
    push_hex(8'(count));
    for (int i = alen - 1; i >= 0; i--) begin
      b   = addr[8*i +: 8];
      sum = sum + b;
      push_hex(b);
    end
    repeat (ndata) begin
      b   = 8'($urandom_range(0, 255));
      sum = sum + b;
      push_hex(b);
    end
    b = ~sum;
    if (flaw == REC_BAD_SUM) b = b ^ (8'd1 << $urandom_range(0, 7));
    push_hex(b);
    hex_end = line_q.size();
    if (flaw == REC_BAD_DIGIT) line_q[$urandom_range(first_hex, hex_end - 1)] = non_hex_char();
    if (flaw == REC_EARLY_NL) begin
      pos = $urandom_range(first_hex, hex_end - 1);
      while (line_q.size() > pos) void'(line_q.pop_back());
    end else begin
      // Text after the checksum is ignored up to the newline.
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
        line_q.push_back(any_char_but(CHAR_NL));
    end
    line_q.push_back(CHAR_NL);
  endtask

  // Record with an unknown type: S4, S6, a non-digit, or a bare S and newline.
  task automatic build_bad_type(input int sel);
    logic [7:0] c;
    line_q.delete();
    line_q.push_back(CHAR_S);
    if (sel == 3) begin
      line_q.push_back(CHAR_NL);
    end else begin
      case (sel)
        0:       line_q.push_back(CHAR_0 + 8'(TYPE_S4));
        1:       line_q.push_back(CHAR_0 + 8'(TYPE_S6));
        default: begin
          do c = any_char_but(CHAR_NL); while (c >= CHAR_0 && c <= CHAR_9);
          line_q.push_back(c);
        end
      endcase
      repeat ($urandom_range(2, 6)) push_hex(8'($urandom_range(0, 255)));
      line_q.push_back(CHAR_NL);
    end
  endtask

  // Record addresses are random or cluster around the window, delete and 24-bit bounds.
  function automatic logic [31:0] pick_addr();
    logic [31:0] near;
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom();
      3:       return 32'($urandom_range(0, 16'hffff));
      4:       near = cfg_shadow[REG_MAP_LOW];
      5:       near = cfg_shadow[REG_MAP_HIGH];
      6:       near = cfg_shadow[REG_DEL_LOW];
      7:       near = cfg_shadow[REG_DEL_HIGH];
      8:       near = ADDR24_MAX + cfg_shadow[REG_BASE_OFFSET];
      default: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
    endcase
    return near + 32'($urandom_range(0, 8)) - 32'd4;
  endfunction

  // Mostly well-formed records with random content, some broken ones.
  task automatic random_record();
    int         pick;
    int         fpick;
    int         ndata;
    logic [3:0] rtype;
    rec_flaw_e  flaw;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      build_bad_type($urandom_range(0, 3));
    end else begin
      if (pick < 31) rtype = TYPE_S1;
      else if (pick < 46) rtype = TYPE_S2;
      else if (pick < 68) rtype = TYPE_S3;
      else if (pick < 74) rtype = TYPE_S0;
      else if (pick < 80) rtype = TYPE_S5;
      else if (pick < 87) rtype = TYPE_S7;
      else if (pick < 94) rtype = TYPE_S8;
      else rtype = TYPE_S9;
      fpick = $urandom_range(0, 99);
      if (fpick < 70) flaw = REC_CLEAN;
      else if (fpick < 80) flaw = REC_BAD_SUM;
      else if (fpick < 87) flaw = REC_BAD_DIGIT;
      else if (fpick < 94) flaw = REC_EARLY_NL;
      else flaw = REC_SHORT_COUNT;
      ndata = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(0, 8);
      build_record(rtype, pick_addr(), ndata, flaw);
    end
    send_line();
  endtask

  // Register settings of one phase, the extremes among them.
  task automatic program_phase(input int p);
    logic [31:0] v[8];
    case (p)
      0: begin
        v[REG_MAP_LOW]     = 32'h0000_1000;
        v[REG_MAP_HIGH]    = 32'h0000_1fff;
        v[REG_MAP_TARGET]  = 32'h00ff_f800;
        v[REG_BASE_OFFSET] = 32'h0;
        v[REG_DEL_ENABLE]  = 32'd1;
        v[REG_DEL_LOW]     = 32'h0000_3000;
        v[REG_DEL_HIGH]    = 32'h0000_30ff;
        v[REG_CUT_ENABLE]  = 32'd0;
      end
      1: begin
        v[REG_MAP_LOW]     = 32'h0;
        v[REG_MAP_HIGH]    = 32'hffff_ffff;
        v[REG_MAP_TARGET]  = 32'hffff_ffff;
        v[REG_BASE_OFFSET] = 32'hffff_ffff;
        v[REG_DEL_ENABLE]  = 32'hffff_ffff;
        v[REG_DEL_LOW]     = 32'hffff_ffff;
        v[REG_DEL_HIGH]    = 32'hffff_ffff;
        v[REG_CUT_ENABLE]  = 32'hffff_ffff;
      end
      3: begin
        // Empty window and a delete range that is switched off.
        v[REG_MAP_LOW]     = 32'hffff_ffff;
        v[REG_MAP_HIGH]    = 32'h0;
        v[REG_MAP_TARGET]  = 32'h0;
        v[REG_BASE_OFFSET] = 32'h1;
        v[REG_DEL_ENABLE]  = 32'd0;
        v[REG_DEL_LOW]     = 32'h0;
        v[REG_DEL_HIGH]    = 32'hffff_ffff;
        v[REG_CUT_ENABLE]  = 32'd1;
      end
      default: begin
        v[REG_MAP_LOW]     = (p == 2) ? $urandom() : $urandom_range(0, 16'hffff);
        v[REG_MAP_HIGH]    = v[REG_MAP_LOW] + $urandom_range(0, 16'h7fff);
        v[REG_MAP_TARGET]  = $urandom();
        v[REG_BASE_OFFSET] = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 255);
        v[REG_DEL_ENABLE]  = 32'($urandom_range(0, 3) != 0);
        v[REG_DEL_LOW]     = (p == 2) ? $urandom() : $urandom_range(0, 16'hffff);
        v[REG_DEL_HIGH]    = v[REG_DEL_LOW] + $urandom_range(0, 16'h3fff);
        v[REG_CUT_ENABLE]  = $urandom_range(0, 1);
      end
    endcase
    for (int r = 0; r < 8; r++) reg_write(cfg_reg_e'(r), v[r]);
  endtask

  // Stimulus and verdict.
  initial begin
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    char_ch.valid     = 1'b0;
    char_ch.text_char = '0;
    res_ch.ready      = 1'b0;
    calm              = 1'b0;
    char_total        = 0;
    foreach (cfg_shadow[i]) cfg_shadow[i] = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed records at the reset settings.
    build_record(TYPE_S0, 32'h0, 3, REC_CLEAN);
    send_line();
    build_record(TYPE_S1, 32'h0, 1, REC_CLEAN);
    send_line();
    build_record(TYPE_S1, 32'hffff, 2, REC_CLEAN);
    send_line();
    build_record(TYPE_S3, 32'hffff_ffff, 1, REC_BAD_SUM);
    send_line();
    build_record(TYPE_S5, 32'h3, 0, REC_CLEAN);
    send_line();
    build_record(TYPE_S9, 32'h0, 0, REC_CLEAN);
    send_line();
    for (int s = 0; s < 4; s++) begin
      build_bad_type(s);
      send_line();
    end
    build_record(TYPE_S2, 32'h12_3456, 2, REC_BAD_DIGIT);
    send_line();
    build_record(TYPE_S2, 32'hab_cdef, 2, REC_EARLY_NL);
    send_line();
    build_record(TYPE_S1, 32'h0100, 1, REC_SHORT_COUNT);
    send_line();
    settle();

    // Random records, one register setting per phase; phase 1 runs calm.
    for (int p = 0; p < NUM_PHASES; p++) begin
      program_phase(p);
      calm       = (p == 1);
      char_total = 0;
      while (char_total < PHASE_CHARS) random_record();
      settle();
    end
    calm = 1'b0;

    if (fail_cnt == 0 && words_left == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
